>>> rtl/core/tdps_pkg.sv
// Shared types and constants for the trial-division prime-sum unit.
`timescale 1ns / 1ps

package tdps_pkg;

	// Fixed widths of the stream fields.
	localparam int CAND_W     = 32;
	localparam int SUM_W      = 64;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 72;

	// First divisor of every test and the smallest prime.
	localparam int DIV_START      = 2;
	localparam int SMALLEST_PRIME = 2;

	// Control states of the test sequencer.
	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_TEST   = 4'b0010,
		S_DIV    = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	// Report of the serial remainder unit.
	typedef struct packed {
		logic done;
		logic zero;
	} rem_status_t;

endpackage

>>> rtl/core/tdps_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps

module tdps_rem import tdps_pkg::*; #(
	parameter int VALUE_WIDTH = 32,
	parameter int DIV_W       = 17
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [DIV_W-1:0]       divisor,
	output rem_status_t            status
);

	localparam int CNT_W = $clog2(VALUE_WIDTH);

	logic [VALUE_WIDTH-1:0] shift_q;
	logic [DIV_W-1:0]       rem_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic                   zero_q;
	logic [DIV_W:0]         trial;
	logic [DIV_W:0]         div_ext;
	logic [DIV_W-1:0]       rem_next;

	// Bring down the next dividend bit and subtract the divisor when it fits.
	assign trial   = {rem_q, shift_q[VALUE_WIDTH-1]};
	assign div_ext = {1'b0, divisor};
	always_comb begin
		if (trial >= div_ext) begin
			rem_next = DIV_W'(trial - div_ext);
		end else begin
			rem_next = trial[DIV_W-1:0];
		end
	end

	// Control: run for one pass over the dividend bits, then report once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shift line and partial remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[VALUE_WIDTH-2:0], 1'b0};
			rem_q   <= rem_next;
			zero_q  <= (rem_next == '0);
		end
	end

	assign status.done = done_q;
	assign status.zero = zero_q;

endmodule

>>> rtl/core/trial_division_prime_sum_unit.sv
// Top level: trial-division primality test with a running sum of primes.
//
// Input stream s_*: one item holds a candidate and a clear_sum flag. The
// unit takes an item only when no test is running; s_tready is high while
// it waits for work, even if the last result has not been taken yet.
// Output stream m_*: one item per input item, carrying the prime flag and
// the 64-bit running sum that includes this candidate when it is prime.
// Each trial divisor d (from 2 while d*d <= candidate) costs one pass of
// the bit-serial remainder unit; the squares are kept by adding 2d+1 per
// step. Candidates below 4 finish without any trial and even candidates
// after a single trial. A new item is taken only once the last test is
// through, so tests never overlap.
// A finished result waits in the output register; if m_tready stays low,
// the next test runs but holds its result until the register frees up.
// Reset clears the running sum, the divisor, the sequencer state and the
// output valid flag.
`timescale 1ns / 1ps

module trial_division_prime_sum_unit import tdps_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [31:0] candidate, [32] clear_sum, [39:33] zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [0] is_prime, [64:1] prime_sum, [71:65] zero
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int DIV_W = (VALUE_WIDTH + 1) / 2 + 1;
	localparam int SQ_W  = 2 * DIV_W;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] n_q;
	logic                   clear_q;
	logic [DIV_W-1:0]       div_q;
	logic [SQ_W-1:0]        sq_q;
	logic                   prime_q;
	logic                   out_prime_q;
	logic                   out_valid_q;
	logic [SUM_W-1:0]       sum_q;

	logic                   in_take;
	logic                   too_small;
	logic                   past_root;
	logic                   rem_start;
	logic                   out_load;
	logic [SQ_W-1:0]        n_ext;
	logic [SUM_W-1:0]       sum_base;
	logic [SUM_W-1:0]       sum_next;
	rem_status_t            rem_st;

	// Handshake and test conditions.
	assign s_tready  = (state_q == S_IDLE);
	assign in_take   = s_tvalid && s_tready;
	assign n_ext     = SQ_W'(n_q);
	assign too_small = (n_q < VALUE_WIDTH'(SMALLEST_PRIME));
	assign past_root = (sq_q > n_ext);
	assign rem_start = (state_q == S_TEST) && !too_small && !past_root;
	assign out_load  = (state_q == S_FINISH) && (!out_valid_q || m_tready);

	// Sum update: clear first, then add a prime candidate.
	assign sum_base = clear_q ? '0 : sum_q;
	assign sum_next = sum_base + (prime_q ? SUM_W'(n_q) : '0);

	tdps_rem #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.DIV_W       (DIV_W)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (n_q),
		.divisor  (div_q),
		.status   (rem_st)
	);

	// Sequencer: check the bound, run one remainder pass, then step the divisor or stop on a zero remainder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			div_q   <= DIV_W'(DIV_START);
			sq_q    <= SQ_W'(DIV_START * DIV_START);
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						div_q   <= DIV_W'(DIV_START);
						sq_q    <= SQ_W'(DIV_START * DIV_START);
						state_q <= S_TEST;
					end
				end
				S_TEST: begin
					if (too_small || past_root) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (rem_st.done) begin
						if (rem_st.zero) begin
							state_q <= S_FINISH;
						end else begin
							sq_q    <= sq_q + SQ_W'({div_q, 1'b1});
							div_q   <= div_q + 1'b1;
							state_q <= S_TEST;
						end
					end
				end
				S_FINISH: begin
					if (out_load) begin
						div_q   <= DIV_W'(DIV_START);
						sq_q    <= SQ_W'(DIV_START * DIV_START);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item payload and verdict of the current test.
	always_ff @(posedge clk) begin
		if (in_take) begin
			n_q     <= s_tdata[VALUE_WIDTH-1:0];
			clear_q <= s_tdata[CAND_W];
		end
		if (state_q == S_TEST) begin
			prime_q <= !too_small;
		end else if ((state_q == S_DIV) && rem_st.done && rem_st.zero) begin
			prime_q <= 1'b0;
		end
	end

	// Output register and running sum, loaded together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sum_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				sum_q       <= sum_next;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_prime_q <= prime_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W - SUM_W - 1)'(0), sum_q, out_prime_q};

	// A new test always starts from the first divisor.
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (div_q == DIV_W'(DIV_START)))
		else $error("divisor not restarted for a new item");

	// The remainder unit only reports while the sequencer waits for it.
	a_rem_owner: assert property (@(posedge clk) disable iff (!arst_n)
		rem_st.done |-> (state_q == S_DIV))
		else $error("remainder report outside the divide state");

	// A prime verdict is only given once the square bound is passed.
	a_prime_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && prime_q) |-> (past_root && !too_small))
		else $error("prime reported before all divisors were tried");

endmodule

>>> sim/trial_division_prime_sum_unit_test.sv
// Self-checking testbench for the trial-division prime-sum unit.
`timescale 1ns / 1ps

module trial_division_prime_sum_unit_test;
	import tdps_pkg::*;

	localparam int VALUE_WIDTH = 32;
	// Slowest item here is a prime near 2^24, which needs about 4096 trials.
	// The limit covers its test several times over.
	localparam int STALL_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 64;
	localparam int RANDOM_ITEMS = 80;

	// Expected prime flag and running sum for one accepted candidate.
	typedef struct packed {
		logic        prime;
		logic [63:0] sum;
	} verdict_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	verdict_t    awaited_verdicts[$];
	logic [63:0] prime_total = '0;
	logic        idling_on = 1'b1;
	int          mismatch_count = 0;
	int          quiet_cycles = 0;

	trial_division_prime_sum_unit #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// Free-running clock, 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Primality by trial division over the masked candidate.
	function automatic logic divides_out(input logic [63:0] n);
		logic [63:0] d;
		if (n < SMALLEST_PRIME)
			return 1'b0;
		for (d = DIV_START; d * d <= n; d++) begin
			if (n % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Offer one candidate after a random gap, if idling_on; valid stays high
	// afterward so that back-to-back items never lower it within one step.
	task automatic offer_candidate(input logic [31:0] cand, input logic clr);
		int gap;
		logic [63:0] n;
		verdict_t v;
		gap = idling_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W - CAND_W - 1){1'b0}}, clr, cand};
		do @(posedge clk); while (!s_tready);
		// Item accepted at this edge: update the running sum.
		n = 64'(cand) & ((64'd1 << VALUE_WIDTH) - 1);
		if (clr)
			prime_total = '0;
		v.prime = divides_out(n);
		if (v.prime)
			prime_total = prime_total + n;
		v.sum = prime_total;
		awaited_verdicts.push_back(v);
	endtask

	// Hold the sender off until every awaited result has been taken.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (awaited_verdicts.size() != 0);
	endtask

	task automatic test_small_values();
		offer_candidate(32'd0, 1'b1);
		offer_candidate(32'd1, 1'b0);
		offer_candidate(32'd2, 1'b0);
		offer_candidate(32'd3, 1'b0);
		offer_candidate(32'd4, 1'b0);
		offer_candidate(32'd5, 1'b0);
	endtask

	// Clearing together with a prime leaves the prime alone in the sum.
	task automatic test_clear_sum();
		offer_candidate(32'd7, 1'b1);
		offer_candidate(32'd9, 1'b1);
		offer_candidate(32'd11, 1'b0);
		offer_candidate(32'd13, 1'b1);
	endtask

	// Full-width patterns all have small factors; the primes stay below 2^24.
	task automatic test_field_extremes();
		offer_candidate(32'hFFFF_FFFF, 1'b0);
		offer_candidate(32'h8000_0000, 1'b0);
		offer_candidate(32'hFFFF_FFFE, 1'b0);
		offer_candidate(32'h5555_5555, 1'b0);
		offer_candidate(32'hAAAA_AAAB, 1'b0);
		offer_candidate(32'd63001, 1'b0);
		offer_candidate(32'd65521, 1'b0);
		offer_candidate(32'd65537, 1'b0);
		offer_candidate(32'd16777213, 1'b0);
	endtask

	task automatic test_drain_pause();
		offer_candidate(32'd97, 1'b0);
		offer_candidate(32'd8191, 1'b0);
		drain_results();
		offer_candidate(32'd101, 1'b0);
		offer_candidate(32'd1000, 1'b0);
	endtask

	// Random candidates: half below 2^16, a tenth below 2^20, and full-width
	// values forced to a small factor so the search ends quickly.
	task automatic test_random_mix(input int count);
		int i;
		int kind;
		int factor;
		logic [31:0] r;
		logic [31:0] cand;
		for (i = 0; i < count; i++) begin
			idling_on = (i >= 20);
			kind = $urandom_range(0, 9);
			if (kind <= 4) begin
				cand = $urandom_range(0, 65535);
			end else if (kind == 5) begin
				cand = $urandom_range(0, (1 << 20) - 1);
			end else begin
				case ($urandom_range(0, 5))
					0: factor = 2;
					1: factor = 3;
					2: factor = 5;
					3: factor = 7;
					4: factor = 11;
					default: factor = 13;
				endcase
				r = $urandom;
				cand = r - (r % factor);
			end
			offer_candidate(cand, $urandom_range(0, 7) == 0);
		end
	endtask

	// Result side: a random stall before each result while idling_on is set.
	initial begin : result_taker
		int stall;
		wait (arst_n);
		forever begin
			stall = idling_on ? $urandom_range(0, 4) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Compare each taken result with the oldest awaited verdict.
	always @(posedge clk) begin : result_check
		verdict_t want;
		logic got_prime;
		logic [63:0] got_sum;
		if (arst_n && m_tvalid && m_tready) begin
			got_prime = m_tdata[0];
			got_sum = m_tdata[64:1];
			if (awaited_verdicts.size() == 0) begin
				$display("%0t: unexpected result: is_prime=%0d prime_sum=%0d",
					$time, got_prime, got_sum);
				mismatch_count++;
			end else begin
				want = awaited_verdicts.pop_front();
				if (got_prime !== want.prime) begin
					$display("%0t: is_prime expected %0d, got %0d",
						$time, want.prime, got_prime);
					mismatch_count++;
				end
				if (got_sum !== want.sum) begin
					$display("%0t: prime_sum expected %0d, got %0d",
						$time, want.sum, got_sum);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: end the run when no item moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_small_values();
		test_clear_sum();
		test_field_extremes();
		test_drain_pause();
		test_random_mix(RANDOM_ITEMS);
		drain_results();
		// Any late extra result shows up here as unexpected.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
